// ===== hdl/bppr_pkg.sv =====
// Package for the buffer pool page replacer: sizes, command and status codes.
// No dependencies.
package bppr_pkg;
    localparam int NUM_FRAMES = 16;
    localparam int FW = $clog2(NUM_FRAMES);
    localparam int PAGE_W = 24;
    localparam int ENTRY_W = 1 + 1 + 16 + 32 + PAGE_W;

    localparam logic [2:0] CMD_PIN = 3'd0;
    localparam logic [2:0] CMD_UNPIN = 3'd1;
    localparam logic [2:0] CMD_DIRTY = 3'd2;
    localparam logic [2:0] CMD_FORCE = 3'd3;
    localparam logic [2:0] CMD_FLUSH = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_RES = 2'd1;
    localparam logic [1:0] ST_ALL_PINNED = 2'd2;
    localparam logic [1:0] ST_UNPIN_ZERO = 2'd3;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_WRITE_READ = 2'd3;

    localparam logic [1:0] MODE_LRU = 2'd1;
    localparam logic [1:0] MODE_CLOCK = 2'd2;

    typedef struct packed {
        logic valid;
        logic dirty;
        logic [15:0] fix;
        logic [31:0] stamp;
        logic [PAGE_W-1:0] page;
    } entry_t;

    typedef struct packed {
        logic [1:0] status;
        logic [FW-1:0] frame;
        logic [1:0] op;
        logic [PAGE_W-1:0] wpage;
        logic last;
    } result_t;
endpackage

// ===== hdl/bppr_frame_ram.sv =====
// Frame table memory: one write port, one registered read port.
// Depends on bppr_pkg.
module bppr_frame_ram
    import bppr_pkg::*;
(
    input  logic          aclk,
    input  logic          we,
    input  logic [FW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [FW-1:0] raddr,
    output entry_t        rdata
);
    entry_t mem [NUM_FRAMES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/bppr_engine.sv =====
// Command sequencer: scans the frame table over the memory port and updates it.
// Depends on bppr_pkg and bppr_frame_ram.
module bppr_engine
    import bppr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        mode,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        in_cmd,
    input  logic [PAGE_W-1:0] in_page,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res,
    output logic [31:0]       reads,
    output logic [31:0]       writes
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_VSCAN = 7'b0000100,
        S_READ  = 7'b0001000,
        S_EXEC  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_CLEAR = 7'b1000000
    } state_t;

    localparam logic [FW:0] NF = (FW+1)'(NUM_FRAMES);

    state_t state_reg, state_next;
    logic [NUM_FRAMES-1:0] valid_reg, valid_next;
    logic [2:0] cmd_reg, cmd_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [FW:0] cnt_reg, cnt_next;
    logic [FW-1:0] addr_reg, addr_next;
    logic hit_reg, hit_next;
    logic [FW-1:0] hitf_reg, hitf_next;
    logic empty_reg, empty_next;
    logic [FW-1:0] emptyf_reg, emptyf_next;
    logic cand_reg, cand_next;
    logic [FW-1:0] candf_reg, candf_next;
    logic [31:0] cands_reg, cands_next;
    logic any_reg, any_next;
    logic [FW-1:0] target_reg, target_next;
    logic [31:0] usec_reg, usec_next;
    logic [FW-1:0] hand_reg, hand_next;
    logic [FW-1:0] head_reg, head_next;
    logic [31:0] rd_reg, rd_next, wr_reg, wr_next;
    logic out_v_reg, out_v_next;
    result_t out_reg, out_next;
    logic pend_reg, pend_next;

    logic we;
    logic [FW-1:0] waddr, raddr;
    entry_t wdata, rdata, ent;

    bppr_frame_ram u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign in_ready = (state_reg == S_IDLE) && !out_v_reg;
    assign res_valid = out_v_reg;
    assign res = out_reg;
    assign reads = rd_reg;
    assign writes = wr_reg;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    always_comb begin
        logic [FW-1:0] idx;
        logic vv;
        state_next = state_reg;
        valid_next = valid_reg;
        cmd_next = cmd_reg;
        page_next = page_reg;
        cnt_next = cnt_reg;
        addr_next = addr_reg;
        hit_next = hit_reg;
        hitf_next = hitf_reg;
        empty_next = empty_reg;
        emptyf_next = emptyf_reg;
        cand_next = cand_reg;
        candf_next = candf_reg;
        cands_next = cands_reg;
        any_next = any_reg;
        target_next = target_reg;
        usec_next = usec_reg;
        hand_next = hand_reg;
        head_next = head_reg;
        rd_next = rd_reg;
        wr_next = wr_reg;
        out_v_next = out_v_reg;
        out_next = out_reg;
        pend_next = pend_reg;
        we = 1'b0;
        waddr = addr_reg;
        wdata = rdata;
        raddr = addr_reg;
        idx = cnt_reg[FW-1:0] - 1'b1;
        vv = valid_reg[idx];
        ent = rdata;
        ent.valid = vv;
        if (!vv) begin
            ent.dirty = 1'b0;
            ent.fix = 16'd0;
            ent.stamp = 32'd0;
        end
        if (out_v_reg && res_ready) begin
            out_v_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                raddr = '0;
                if (in_valid && in_ready) begin
                    cmd_next = in_cmd;
                    page_next = in_page;
                    cnt_next = '0;
                    hit_next = 1'b0;
                    empty_next = 1'b0;
                    cand_next = 1'b0;
                    any_next = 1'b0;
                    if (in_cmd > CMD_FLUSH) begin
                        out_next = '{ST_OK, '0, OP_NONE, '0, 1'b1};
                        out_v_next = 1'b1;
                    end else begin
                        state_next = in_cmd == CMD_FLUSH ? S_CLEAR : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Issue read for entry cnt, examine entry cnt-1.
                raddr = cnt_reg[FW-1:0];
                if (cnt_reg != '0) begin
                    if (vv && rdata.page == page_reg && !hit_reg) begin
                        hit_next = 1'b1;
                        hitf_next = idx;
                    end
                    if (!vv && !empty_reg) begin
                        empty_next = 1'b1;
                        emptyf_next = idx;
                    end
                    if (ent.fix == 16'd0 &&
                        (!cand_reg || ent.stamp < cands_reg)) begin
                        cand_next = 1'b1;
                        candf_next = idx;
                        cands_next = ent.stamp;
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == NF) begin
                    if (hit_next) begin
                        target_next = hitf_next;
                        addr_next = hitf_next;
                        state_next = S_READ;
                    end else if (cmd_reg != CMD_PIN) begin
                        out_next = '{ST_NOT_RES, '0, OP_NONE, '0, 1'b1};
                        out_v_next = 1'b1;
                        state_next = S_IDLE;
                    end else if (empty_next) begin
                        target_next = emptyf_next;
                        addr_next = emptyf_next;
                        state_next = S_READ;
                    end else if (!cand_next) begin
                        out_next = '{ST_ALL_PINNED, '0, OP_NONE, '0, 1'b1};
                        out_v_next = 1'b1;
                        state_next = S_IDLE;
                    end else if (mode == MODE_LRU) begin
                        target_next = candf_next;
                        addr_next = candf_next;
                        state_next = S_READ;
                    end else begin
                        addr_next = mode == MODE_CLOCK ? hand_reg : head_reg;
                        pend_next = 1'b0;
                        state_next = S_VSCAN;
                    end
                end
            end
            S_VSCAN: begin
                // Each entry is handled in two steps: read, then decide.
                if (!pend_reg) begin
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    addr_next = addr_reg + 1'b1;
                    if (rdata.fix == 16'd0 &&
                        (mode != MODE_CLOCK || rdata.stamp == 32'd0)) begin
                        target_next = addr_reg;
                        if (mode == MODE_CLOCK) begin
                            hand_next = addr_reg + 1'b1;
                        end else begin
                            head_next = addr_reg + 1'b1;
                        end
                        addr_next = addr_reg;
                        state_next = S_READ;
                    end else if (rdata.fix == 16'd0) begin
                        we = 1'b1;
                        waddr = addr_reg;
                        wdata = rdata;
                        wdata.stamp = 32'd0;
                    end
                end
            end
            S_READ: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_IDLE;
                out_v_next = 1'b1;
                waddr = target_reg;
                wdata = rdata;
                out_next = '{ST_OK, target_reg, OP_NONE, '0, 1'b1};
                case (cmd_reg)
                    CMD_PIN: begin
                        we = 1'b1;
                        usec_next = usec_reg + 32'd1;
                        if (hit_reg) begin
                            if (rdata.fix != 16'hFFFF) wdata.fix = rdata.fix + 16'd1;
                            if (mode == MODE_LRU) wdata.stamp = usec_next;
                            else if (mode == MODE_CLOCK) wdata.stamp = 32'd1;
                        end else begin
                            out_next.op = OP_READ;
                            if (valid_reg[target_reg] && rdata.dirty) begin
                                wr_next = sat_inc(wr_reg);
                                out_next.op = OP_WRITE_READ;
                                out_next.wpage = rdata.page;
                            end
                            rd_next = sat_inc(rd_reg);
                            valid_next[target_reg] = 1'b1;
                            wdata.valid = 1'b1;
                            wdata.dirty = 1'b0;
                            wdata.fix = 16'd1;
                            wdata.page = page_reg;
                            wdata.stamp = mode == MODE_LRU ? usec_next :
                                          mode == MODE_CLOCK ? 32'd1 : 32'd0;
                        end
                    end
                    CMD_UNPIN: begin
                        if (rdata.fix == 16'd0) begin
                            out_next.status = ST_UNPIN_ZERO;
                        end else begin
                            we = 1'b1;
                            wdata.fix = rdata.fix - 16'd1;
                        end
                    end
                    CMD_DIRTY: begin
                        we = 1'b1;
                        wdata.dirty = 1'b1;
                    end
                    default: begin
                        we = 1'b1;
                        wdata.dirty = 1'b0;
                        wr_next = sat_inc(wr_reg);
                        out_next.op = OP_WRITE;
                        out_next.wpage = rdata.page;
                    end
                endcase
            end
            S_CLEAR: begin
                // Flush: read entry cnt, act on entry cnt-1 when the output is free.
                // Each written frame is held back until the next one is found, so
                // that the final word of the command can carry last.
                raddr = cnt_reg[FW-1:0];
                if (cnt_reg == '0) begin
                    cnt_next = (FW+1)'(1);
                end else if (!out_v_reg) begin
                    if (vv && rdata.dirty && rdata.fix == 16'd0) begin
                        we = 1'b1;
                        waddr = idx;
                        wdata = rdata;
                        wdata.dirty = 1'b0;
                        if (any_reg) begin
                            wr_next = sat_inc(wr_reg);
                            out_next = '{ST_OK, target_reg, OP_WRITE, page_reg, 1'b0};
                            out_v_next = 1'b1;
                        end
                        any_next = 1'b1;
                        target_next = idx;
                        page_next = rdata.page;
                    end
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == NF) begin
                        state_next = S_EMIT;
                    end
                end else begin
                    raddr = idx;
                end
            end
            S_EMIT: begin
                if (!out_v_reg) begin
                    state_next = S_IDLE;
                    if (any_reg) begin
                        wr_next = sat_inc(wr_reg);
                        out_next = '{ST_OK, target_reg, OP_WRITE, page_reg, 1'b1};
                    end else begin
                        out_next = '{ST_OK, '0, OP_NONE, '0, 1'b1};
                    end
                    out_v_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            usec_reg <= '0;
            hand_reg <= '0;
            head_reg <= '0;
            rd_reg <= '0;
            wr_reg <= '0;
            out_v_reg <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            usec_reg <= usec_next;
            hand_reg <= hand_next;
            head_reg <= head_next;
            rd_reg <= rd_next;
            wr_reg <= wr_next;
            out_v_reg <= out_v_next;
            pend_reg <= pend_next;
        end
        cmd_reg <= cmd_next;
        page_reg <= page_next;
        cnt_reg <= cnt_next;
        addr_reg <= addr_next;
        hit_reg <= hit_next;
        hitf_reg <= hitf_next;
        empty_reg <= empty_next;
        emptyf_reg <= emptyf_next;
        cand_reg <= cand_next;
        candf_reg <= candf_next;
        cands_reg <= cands_next;
        any_reg <= any_next;
        target_reg <= target_next;
        out_reg <= out_next;
    end
endmodule

// ===== hdl/buffer_pool_page_replacer_unit.sv =====
// Buffer pool page replacer. A command scans the sixteen frame entries through the
// single read port of the frame memory, then reads and writes back the chosen frame.
// A clock or FIFO victim search adds a read step and a decide step per frame visited,
// up to 32 frames for clock and 16 for FIFO; flush all visits each frame and waits
// while the downstream side holds each result word.
// A new command is taken only after the last result word of the previous one is accepted.
// Depends on bppr_pkg and bppr_engine.
module buffer_pool_page_replacer_unit
    import bppr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // cmd[2:0], page_num[26:3], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // status, frame_index, disk_op, write_page,
                                   // read_count, write_count
    output logic        m_tlast
);
    logic [1:0] mode_reg;
    result_t r;
    logic [31:0] rc, wc;

    always_ff @(posedge aclk) begin
        if (!aresetn) mode_reg <= 2'd0;
        else if (cfg_we) mode_reg <= cfg_wdata;
    end

    bppr_engine u_eng (
        .aclk(aclk), .aresetn(aresetn), .mode(mode_reg),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tdata[2:0]), .in_page(s_tdata[26:3]),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(r),
        .reads(rc), .writes(wc)
    );

    assign m_tdata = {wc, rc, r.wpage, r.op, r.frame, r.status};
    assign m_tlast = r.last;
endmodule

// ===== hdl/bppr_checker.sv =====
// Port checker for the buffer pool page replacer, bound to the top level.
// Depends on buffer_pool_page_replacer_unit.
module bppr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");
    a_wc_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && $past(m_tvalid) |-> m_tdata[95:64] >= $past(m_tdata[95:64]))
        else $error("write count went down");
    a_rc_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && $past(m_tvalid) |-> m_tdata[63:32] >= $past(m_tdata[63:32]))
        else $error("read count went down");
    a_op_page: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[7] |-> m_tdata[31:8] == 24'd0)
        else $error("write page without write back");
    a_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input ready while a result word waits");
endmodule

bind buffer_pool_page_replacer_unit bppr_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== verif/tb.sv =====
// Self-checking testbench for buffer_pool_page_replacer_unit: a queue-fed stream
// driver, a result monitor and a frame table predictor that runs through all policies.
// Depends on bppr_pkg and the RTL of the replacer.
`timescale 1ns / 1ps

module tb
    import bppr_pkg::*;
();

    localparam logic [1:0] MODE_FIFO = 2'd0;
    localparam logic [1:0] MODE_ODD = 2'd3;
    localparam logic [2:0] CMD_UNKNOWN = 3'd5;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] frame;
        logic [1:0] op;
        logic [23:0] wpage;
        logic last;
        logic [31:0] reads;
        logic [31:0] writes;
    } page_result_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [1:0] cfg_wdata = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [95:0] m_tdata;
    logic m_tlast;

    logic [31:0] word_queue[$];
    page_result_t pending_results[$];
    logic [23:0] page_pool[24];
    int error_count = 0;
    logic word_taken = 0;
    logic no_idle = 0;
    int hold_requests = 0;
    int holds_seen = 0;
    int hold_left = 0;

    logic [23:0] fr_page[NUM_FRAMES];
    logic fr_valid[NUM_FRAMES];
    logic fr_dirty[NUM_FRAMES];
    logic [15:0] fr_fix[NUM_FRAMES];
    logic [31:0] fr_stamp[NUM_FRAMES];
    logic [31:0] use_count = 0;
    logic [3:0] hand = 0;
    logic [3:0] fifo_next = 0;
    logic [31:0] disk_reads = 0;
    logic [31:0] disk_writes = 0;
    logic [1:0] policy = MODE_FIFO;

    buffer_pool_page_replacer_unit DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void add_result(logic [1:0] st, int fr, logic [1:0] op,
                                       logic [23:0] wp);
        page_result_t r;
        r.status = st;
        r.frame = fr[3:0];
        r.op = op;
        r.wpage = wp;
        r.last = 0;
        r.reads = disk_reads;
        r.writes = disk_writes;
        pending_results.push_back(r);
    endfunction

    function automatic void count_up(ref logic [31:0] c);
        if (c != 32'hFFFF_FFFF) c++;
    endfunction

    function automatic int lookup_frame(logic [23:0] pg);
        for (int i = 0; i < NUM_FRAMES; i++)
            if (fr_valid[i] && fr_page[i] == pg) return i;
        return -1;
    endfunction

    function automatic int pick_victim();
        int best;
        int idx;
        bit any_free;
        best = -1;
        any_free = 0;
        for (int i = 0; i < NUM_FRAMES; i++)
            if (fr_fix[i] == 0) any_free = 1;
        if (!any_free) return -1;
        if (policy == MODE_LRU) begin
            for (int i = 0; i < NUM_FRAMES; i++)
                if (fr_fix[i] == 0 && (best < 0 || fr_stamp[i] < fr_stamp[best])) best = i;
            return best;
        end
        if (policy == MODE_CLOCK) begin
            for (int s = 0; s < 2 * NUM_FRAMES + 1; s++) begin
                idx = hand;
                hand = hand + 4'd1;
                if (fr_fix[idx] != 0) continue;
                if (fr_stamp[idx] == 0) return idx;
                fr_stamp[idx] = 0;
            end
            return -1;
        end
        for (int s = 0; s < NUM_FRAMES; s++) begin
            idx = (fifo_next + s) % NUM_FRAMES;
            if (fr_fix[idx] == 0) begin
                fifo_next = 4'(idx + 1);
                return idx;
            end
        end
        return -1;
    endfunction

    function automatic void predict_command(logic [31:0] w);
        logic [2:0] cmd;
        logic [23:0] pg;
        int f;
        int n;
        logic [1:0] op;
        logic [23:0] wp;
        cmd = w[2:0];
        pg = w[26:3];
        n = pending_results.size();
        if (cmd == CMD_PIN) begin
            f = lookup_frame(pg);
            if (f >= 0) begin
                if (fr_fix[f] != 16'hFFFF) fr_fix[f]++;
                use_count++;
                if (policy == MODE_LRU) fr_stamp[f] = use_count;
                else if (policy == MODE_CLOCK) fr_stamp[f] = 1;
                add_result(ST_OK, f, OP_NONE, '0);
            end else begin
                op = OP_READ;
                wp = '0;
                for (int i = NUM_FRAMES - 1; i >= 0; i--)
                    if (!fr_valid[i]) f = i;
                if (f < 0) begin
                    f = pick_victim();
                    if (f >= 0 && fr_dirty[f]) begin
                        count_up(disk_writes);
                        op = OP_WRITE_READ;
                        wp = fr_page[f];
                    end
                end
                if (f < 0) begin
                    add_result(ST_ALL_PINNED, 0, OP_NONE, '0);
                end else begin
                    use_count++;
                    fr_page[f] = pg;
                    fr_valid[f] = 1;
                    fr_dirty[f] = 0;
                    fr_fix[f] = 1;
                    fr_stamp[f] = (policy == MODE_LRU) ? use_count :
                                  (policy == MODE_CLOCK) ? 32'd1 : 32'd0;
                    count_up(disk_reads);
                    add_result(ST_OK, f, op, wp);
                end
            end
        end else if (cmd == CMD_UNPIN || cmd == CMD_DIRTY || cmd == CMD_FORCE) begin
            f = lookup_frame(pg);
            if (f < 0) begin
                add_result(ST_NOT_RES, 0, OP_NONE, '0);
            end else if (cmd == CMD_UNPIN) begin
                if (fr_fix[f] == 0) begin
                    add_result(ST_UNPIN_ZERO, f, OP_NONE, '0);
                end else begin
                    fr_fix[f]--;
                    add_result(ST_OK, f, OP_NONE, '0);
                end
            end else if (cmd == CMD_DIRTY) begin
                fr_dirty[f] = 1;
                add_result(ST_OK, f, OP_NONE, '0);
            end else begin
                fr_dirty[f] = 0;
                count_up(disk_writes);
                add_result(ST_OK, f, OP_WRITE, fr_page[f]);
            end
        end else if (cmd == CMD_FLUSH) begin
            for (int i = 0; i < NUM_FRAMES; i++)
                if (fr_valid[i] && fr_dirty[i] && fr_fix[i] == 0) begin
                    fr_dirty[i] = 0;
                    count_up(disk_writes);
                    add_result(ST_OK, i, OP_WRITE, fr_page[i]);
                end
            if (pending_results.size() == n) add_result(ST_OK, 0, OP_NONE, '0);
        end else begin
            add_result(ST_OK, 0, OP_NONE, '0);
        end
        pending_results[pending_results.size() - 1].last = 1;
    endfunction

    // Input side: a word is consumed at the edge where tvalid and tready meet.
    always @(posedge aclk) begin
        word_taken <= s_tvalid && s_tready && aresetn;
        if (aresetn && s_tvalid && s_tready) predict_command(s_tdata);
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || word_taken)) begin
            if (word_queue.size() > 0 && (no_idle || $urandom_range(99) >= 28)) begin
                s_tdata <= word_queue.pop_front();
                s_tvalid <= 1;
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_requests != holds_seen) begin
            holds_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 0;
        end else begin
            m_tready <= aresetn && (no_idle || $urandom_range(99) >= 28);
        end
    end

    always @(posedge aclk) begin
        page_result_t got;
        page_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[1:0], m_tdata[5:2], m_tdata[7:6], m_tdata[31:8], m_tlast,
                   m_tdata[63:32], m_tdata[95:64]};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                if (got.frame !== want.frame)
                    $display("%0t: frame exp %0d got %0d", $time, want.frame, got.frame);
                if (got.op !== want.op)
                    $display("%0t: disk_op exp %0d got %0d", $time, want.op, got.op);
                if (got.wpage !== want.wpage)
                    $display("%0t: write_page exp %h got %h", $time, want.wpage, got.wpage);
                if (got.last !== want.last)
                    $display("%0t: tlast exp %0d got %0d", $time, want.last, got.last);
                if (got.reads !== want.reads)
                    $display("%0t: read_count exp %0d got %0d", $time, want.reads, got.reads);
                if (got.writes !== want.writes)
                    $display("%0t: write_count exp %0d got %0d", $time, want.writes,
                             got.writes);
                if (got !== want) error_count++;
            end
        end
    end

    task automatic send(logic [2:0] cmd, logic [23:0] pg);
        word_queue.push_back({5'b0, pg, cmd});
    endtask

    task automatic drain();
        while (word_queue.size() > 0 || s_tvalid || pending_results.size() > 0)
            @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic set_policy(logic [1:0] m);
        cfg_we <= 1;
        cfg_wdata <= m;
        @(negedge aclk);
        cfg_we <= 0;
        policy = m;
    endtask

    task automatic random_commands(int count);
        logic [2:0] cmd;
        logic [23:0] pg;
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            cmd = r < 40 ? CMD_PIN : r < 70 ? CMD_UNPIN : r < 82 ? CMD_DIRTY :
                  r < 88 ? CMD_FORCE : r < 94 ? CMD_FLUSH : 3'($urandom_range(7, 5));
            pg = ($urandom_range(9) == 0) ? 24'($urandom) : page_pool[$urandom_range(23)];
            send(cmd, pg);
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
            fr_valid[i] = 0;
            fr_dirty[i] = 0;
            fr_fix[i] = 0;
            fr_stamp[i] = 0;
            fr_page[i] = 0;
        end
        for (int i = 0; i < 24; i++) page_pool[i] = 24'($urandom);
        page_pool[0] = 24'h000000;
        page_pool[1] = 24'hFFFFFF;
        repeat (8) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Fill every frame, then hit all-pinned, unpin past zero and evict.
        no_idle = 1;
        for (int i = 0; i < NUM_FRAMES; i++) send(CMD_PIN, page_pool[i]);
        send(CMD_PIN, page_pool[20]);
        send(CMD_UNPIN, page_pool[0]);
        send(CMD_UNPIN, page_pool[0]);
        send(CMD_DIRTY, page_pool[1]);
        send(CMD_FLUSH, 24'h0);
        send(CMD_UNPIN, page_pool[1]);
        send(CMD_FLUSH, 24'hFFFFFF);
        send(CMD_DIRTY, page_pool[2]);
        send(CMD_UNPIN, page_pool[2]);
        send(CMD_PIN, page_pool[21]);
        send(CMD_PIN, page_pool[22]);
        send(CMD_FORCE, page_pool[5]);
        send(CMD_UNPIN, page_pool[23]);
        send(CMD_UNKNOWN, 24'hFFFFFF);
        drain();
        no_idle = 0;

        hold_requests = hold_requests + 1;
        random_commands(15);
        drain();
        set_policy(MODE_LRU);
        random_commands(20);
        drain();
        set_policy(MODE_CLOCK);
        random_commands(20);
        drain();
        set_policy(MODE_ODD);
        random_commands(10);
        drain();
        set_policy(MODE_FIFO);
        random_commands(10);
        drain();

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== buffer_pool_page_replacer_unit.f =====
hdl/bppr_pkg.sv
hdl/bppr_frame_ram.sv
hdl/bppr_engine.sv
hdl/buffer_pool_page_replacer_unit.sv
hdl/bppr_checker.sv
verif/tb.sv
